@@ hdl/kpi_pkg.sv @@
// ----------------------------------------------------------------------------
// kpi_pkg
// Shared types and constants for the keyboard port interface unit.
// ----------------------------------------------------------------------------
package kpi_pkg;

  // item kinds carried in in_tuser
  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  // port offsets from the base address
  localparam logic [1:0] PORT_A = 2'd0;
  localparam logic [1:0] PORT_B = 2'd1;
  localparam logic [1:0] PORT_C = 2'd2;
  localparam logic [1:0] PORT_D = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_SWITCH_BYTE  = 3'd0;
  localparam logic [2:0] REG_FPU_PRESENT  = 3'd1;
  localparam logic [2:0] REG_PA_MODE      = 3'd2;
  localparam logic [2:0] REG_TICK_IGN_CLK = 3'd3;
  localparam logic [2:0] REG_CLK_IGN_CLR  = 3'd4;
  localparam logic [2:0] REG_PC_SEL_PB2   = 3'd5;
  localparam logic [2:0] REG_PD_READABLE  = 3'd6;

  // port A read modes while PB7 is set
  localparam logic [1:0] PA_MODE_LATCH    = 2'd0;
  localparam logic [1:0] PA_MODE_SWITCHES = 2'd1;

  // fixed codes and masks
  localparam logic [7:0] SELF_TEST_CODE = 8'haa;
  localparam logic [7:0] ALL_ONES       = 8'hff;
  localparam logic [7:0] SW_FPU_MASK    = 8'hfd;
  localparam logic [3:0] SW_LOW_MASK    = 4'hd;
  localparam int         PB_CLOCK_BIT   = 6;
  localparam int         PB_CLEAR_BIT   = 7;
  localparam int         PB_SEL_LOW_BIT = 2;
  localparam int         PB_SEL_HI_BIT  = 3;
  localparam int         PC_SPK_BIT     = 5;
  localparam int         SW_FPU_BIT     = 1;

  // configuration registers as seen by the core
  typedef struct packed {
    logic [7:0] switch_byte;
    logic       fpu_present;
    logic [1:0] port_a_switch_mode;
    logic       tick_ignores_clock;
    logic       clock_ignores_clear_bit;
    logic       port_c_select_pb2;
    logic       port_d_readable;
  } cfg_regs_t;

  // requests to the code ring for one beat
  typedef struct packed {
    logic       clear;
    logic       push;
    logic       pop;
    logic [7:0] data;
  } ring_ctrl_t;

  // code ring status
  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] head;
  } ring_stat_t;

endpackage

@@ hdl/kpi_apb_regs.sv @@
// ----------------------------------------------------------------------------
// kpi_apb_regs
// APB configuration registers of the keyboard port interface unit.
// ----------------------------------------------------------------------------
module kpi_apb_regs
  import kpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_regs_t   cfg
);

  cfg_regs_t  cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.switch_byte             <= 8'h00;
      cfg_r.fpu_present             <= 1'b0;
      cfg_r.port_a_switch_mode      <= PA_MODE_SWITCHES;
      cfg_r.tick_ignores_clock      <= 1'b0;
      cfg_r.clock_ignores_clear_bit <= 1'b0;
      cfg_r.port_c_select_pb2       <= 1'b0;
      cfg_r.port_d_readable         <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SWITCH_BYTE:  cfg_r.switch_byte             <= cfg_pwdata[7:0];
        REG_FPU_PRESENT:  cfg_r.fpu_present             <= cfg_pwdata[0];
        REG_PA_MODE:      cfg_r.port_a_switch_mode      <= cfg_pwdata[1:0];
        REG_TICK_IGN_CLK: cfg_r.tick_ignores_clock      <= cfg_pwdata[0];
        REG_CLK_IGN_CLR:  cfg_r.clock_ignores_clear_bit <= cfg_pwdata[0];
        REG_PC_SEL_PB2:   cfg_r.port_c_select_pb2       <= cfg_pwdata[0];
        REG_PD_READABLE:  cfg_r.port_d_readable         <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_SWITCH_BYTE:  cfg_prdata = {24'd0, cfg_r.switch_byte};
      REG_FPU_PRESENT:  cfg_prdata = {31'd0, cfg_r.fpu_present};
      REG_PA_MODE:      cfg_prdata = {30'd0, cfg_r.port_a_switch_mode};
      REG_TICK_IGN_CLK: cfg_prdata = {31'd0, cfg_r.tick_ignores_clock};
      REG_CLK_IGN_CLR:  cfg_prdata = {31'd0, cfg_r.clock_ignores_clear_bit};
      REG_PC_SEL_PB2:   cfg_prdata = {31'd0, cfg_r.port_c_select_pb2};
      REG_PD_READABLE:  cfg_prdata = {31'd0, cfg_r.port_d_readable};
      default:          cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ hdl/kpi_code_ring.sv @@
// ----------------------------------------------------------------------------
// kpi_code_ring
// Scan-code ring: one write port, one registered read port that always holds
// the entry at the read pointer, with forwarding of a same-cycle write.
// ----------------------------------------------------------------------------
module kpi_code_ring
  import kpi_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  ring_ctrl_t ctrl,
  output ring_stat_t stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [7:0]       mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_base, wr_base;
  logic [PTR_W-1:0] wr_next_slot, rd_next_slot;
  logic [7:0]       head_r;

  // pointer after the current one, wrapping at the depth
  always_comb begin
    wr_next_slot = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    rd_next_slot = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
  end

  // status from the current pointers
  assign stat.empty = (rd_ptr_r == wr_ptr_r);
  assign stat.full  = (wr_next_slot == rd_ptr_r);
  assign stat.head  = head_r;

  // next pointers, a clear empties the ring before any push
  always_comb begin
    rd_base    = ctrl.clear ? '0 : rd_ptr_r;
    wr_base    = ctrl.clear ? '0 : wr_ptr_r;
    rd_ptr_nxt = ctrl.pop ? rd_next_slot : rd_base;
    wr_ptr_nxt = wr_base;
    if (ctrl.push) begin
      wr_ptr_nxt = (wr_base == PTR_LAST) ? '0 : wr_base + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
    end
  end

  // storage and registered head read
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_base] <= ctrl.data;
    end
    if (ctrl.push && (wr_base == rd_ptr_nxt)) begin
      head_r <= ctrl.data;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

endmodule

@@ hdl/xt_keyboard_port_interface_unit.sv @@
// ----------------------------------------------------------------------------
// xt_keyboard_port_interface_unit
// XT keyboard port: scan-code ring and PPI ports A to D with keyboard IRQ.
// ----------------------------------------------------------------------------
// Usage: each input beat carries one bus event, its kind in in_tuser (key
// code arrives, port write, port read, tick) and port offset, write byte,
// scan code and speaker level in in_tdata. Every input beat yields exactly
// one output beat with the read byte, IRQ level, port B byte and a flag set
// when a key code was dropped on a full ring.
// Throughput is one beat per cycle while out_tready is high; each beat goes
// through the input register, then the result register. The ring's head is
// kept in a register read from the ring memory at the pointer left by the
// previous beat, so back-to-back ticks and pushes never wait. A stalled
// output keeps its beat; the input register still takes a beat while it is
// empty, then in_tready drops. Reset (rst_n low at a clock edge) empties the
// ring, clears ports A and B, the IRQ and delivery state, and loads the
// register defaults. No clearing pass runs; the ring contents are only used
// after being written. The user must write the configuration registers
// through the APB port while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module xt_keyboard_port_interface_unit
  import kpi_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
)
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // port_offset[1:0], write_data[9:2],
                                  // scan_code[17:10], speaker_level[18], zeros
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // read_data[7:0], irq_line[8],
                                  // port_b_value[16:9], key_dropped[17], zeros
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_regs_t  cfg;
  ring_ctrl_t ring_ctrl;
  ring_stat_t ring_stat;

  // input register
  logic       in_vld_r;
  cmd_t       cmd_r;
  logic [1:0] port_r;
  logic [7:0] wdata_r;
  logic [7:0] code_r;
  logic       spk_r;
  logic       fire;

  // ppi state
  logic [7:0] pa_r, pa_nxt;
  logic [7:0] pb_r, pb_nxt;
  logic       clk_lvl_r, clk_lvl_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic       irq_pend_r, irq_pend_nxt;
  logic       blocked_r, blocked_nxt;
  logic       irq_r, irq_nxt;

  // result register
  logic       out_vld_r;
  logic [7:0] rdata_r, rdata_nxt;
  logic       drop_r, drop_nxt;

  // helpers
  logic       tick_on;
  logic       track;
  logic       high_nib;
  logic [7:0] sw_fpu;
  logic [7:0] pc_val;

  kpi_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  kpi_code_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ring_ctrl),
    .stat  (ring_stat)
  );

  // handshake: the held beat moves on when the result register is free or being drained
  assign fire      = in_vld_r & (~out_vld_r | out_tready);
  assign in_tready = ~in_vld_r | fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= cmd_t'(in_tuser);
      port_r  <= in_tdata[1:0];
      wdata_r <= in_tdata[9:2];
      code_r  <= in_tdata[17:10];
      spk_r   <= in_tdata[18];
    end
  end

  // switch views
  always_comb begin
    sw_fpu             = cfg.switch_byte & SW_FPU_MASK;
    sw_fpu[SW_FPU_BIT] = cfg.fpu_present;
    if (cfg.port_c_select_pb2) begin
      high_nib = ~pb_r[PB_SEL_LOW_BIT];
    end else begin
      high_nib = pb_r[PB_SEL_HI_BIT];
    end
    if (high_nib) begin
      pc_val = {4'd0, cfg.switch_byte[7:4]};
    end else begin
      pc_val             = {4'd0, cfg.switch_byte[3:0] & SW_LOW_MASK};
      pc_val[SW_FPU_BIT] = cfg.fpu_present;
    end
    pc_val[PC_SPK_BIT] = pc_val[PC_SPK_BIT] | spk_r;
  end

  // next state and result for the held beat
  always_comb begin
    pa_nxt       = pa_r;
    pb_nxt       = pb_r;
    clk_lvl_nxt  = clk_lvl_r;
    wait_nxt     = wait_r;
    irq_pend_nxt = irq_pend_r;
    blocked_nxt  = blocked_r;
    irq_nxt      = irq_r;
    rdata_nxt    = 8'h00;
    drop_nxt     = 1'b0;
    ring_ctrl    = '0;
    tick_on      = pb_r[PB_CLOCK_BIT] | cfg.tick_ignores_clock;
    track        = ~wdata_r[PB_CLEAR_BIT] | cfg.clock_ignores_clear_bit;

    case (cmd_r)
      CMD_KEY: begin
        ring_ctrl.data = code_r;
        ring_ctrl.push = fire & ~ring_stat.full;
        drop_nxt       = ring_stat.full;
      end
      CMD_WRITE: begin
        if (port_r == PORT_B) begin
          // clock edge resets the ring and queues the self-test code
          if (track && !clk_lvl_r && wdata_r[PB_CLOCK_BIT]) begin
            ring_ctrl.clear = fire;
            ring_ctrl.push  = fire;
            ring_ctrl.data  = SELF_TEST_CODE;
            irq_pend_nxt    = 1'b0;
            blocked_nxt     = 1'b0;
          end
          pb_nxt = wdata_r;
          if (track) begin
            clk_lvl_nxt = wdata_r[PB_CLOCK_BIT];
          end
          // clear bit drops port A and the interrupt
          if (wdata_r[PB_CLEAR_BIT]) begin
            pa_nxt      = 8'h00;
            blocked_nxt = 1'b0;
            irq_nxt     = 1'b0;
          end
        end
      end
      CMD_READ: begin
        case (port_r)
          PORT_A: begin
            if (pb_r[PB_CLEAR_BIT] && cfg.port_a_switch_mode != PA_MODE_LATCH) begin
              rdata_nxt = (cfg.port_a_switch_mode == PA_MODE_SWITCHES) ? sw_fpu : ALL_ONES;
            end else begin
              rdata_nxt = pa_r;
            end
          end
          PORT_B:  rdata_nxt = pb_r;
          PORT_C:  rdata_nxt = pc_val;
          default: rdata_nxt = cfg.port_d_readable ? cfg.switch_byte : ALL_ONES;
        endcase
      end
      default: begin
        // tick: deliver the waiting code, then fetch the next one
        if (tick_on) begin
          if (irq_pend_r) begin
            irq_pend_nxt = 1'b0;
            pa_nxt       = wait_r;
            blocked_nxt  = 1'b1;
            irq_nxt      = 1'b1;
          end
          if (!ring_stat.empty && !blocked_nxt) begin
            wait_nxt      = ring_stat.head;
            ring_ctrl.pop = fire;
            irq_pend_nxt  = 1'b1;
          end
        end
      end
    endcase
  end

  // ppi state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_r       <= 8'h00;
      pb_r       <= 8'h00;
      clk_lvl_r  <= 1'b0;
      wait_r     <= 8'h00;
      irq_pend_r <= 1'b0;
      blocked_r  <= 1'b0;
      irq_r      <= 1'b0;
    end else if (fire) begin
      pa_r       <= pa_nxt;
      pb_r       <= pb_nxt;
      clk_lvl_r  <= clk_lvl_nxt;
      wait_r     <= wait_nxt;
      irq_pend_r <= irq_pend_nxt;
      blocked_r  <= blocked_nxt;
      irq_r      <= irq_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rdata_r <= rdata_nxt;
      drop_r  <= drop_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, drop_r, pb_r, irq_r, rdata_r};

endmodule
